@@ design/ctd_pkg.sv @@
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types, constants and helpers for the chunked transfer decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam int unsigned CountW    = 32;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // largest partial size that still takes one more hex digit
  localparam logic [CountW-1:0] SizeLimit = {CountW{1'b1}} >> 4;

  localparam int unsigned InDataW  = 40;  // byte_in + consume_count, byte aligned
  localparam int unsigned OutDataW = 40;  // phase_code + bytes_left, byte aligned

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_CONSUME = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  // byte classes that matter to the framing parser
  typedef enum logic [2:0] {
    CLS_CR    = 3'd0,
    CLS_LF    = 3'd1,
    CLS_WS    = 3'd2,
    CLS_SEMI  = 3'd3,
    CLS_HEX   = 3'd4,
    CLS_OTHER = 3'd5
  } cls_e;

  typedef enum logic [6:0] {
    PH_SIZE    = 7'b000_0001,
    PH_EXT     = 7'b000_0010,
    PH_DATA    = 7'b000_0100,
    PH_DEND    = 7'b000_1000,
    PH_TRAILER = 7'b001_0000,
    PH_DONE    = 7'b010_0000,
    PH_INVALID = 7'b100_0000
  } phase_e;

  localparam logic [2:0] CodeSize    = 3'd0;
  localparam logic [2:0] CodeExt     = 3'd1;
  localparam logic [2:0] CodeData    = 3'd2;
  localparam logic [2:0] CodeDend    = 3'd3;
  localparam logic [2:0] CodeTrailer = 3'd4;
  localparam logic [2:0] CodeDone    = 3'd5;
  localparam logic [2:0] CodeInvalid = 3'd6;

  // classified word travelling from front to back
  typedef struct packed {
    req_e              req;
    cls_e              cls;
    logic [3:0]        hex;
    logic [CountW-1:0] count;
  } cmd_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    unique case (ph)
      PH_SIZE:    code = CodeSize;
      PH_EXT:     code = CodeExt;
      PH_DATA:    code = CodeData;
      PH_DEND:    code = CodeDend;
      PH_TRAILER: code = CodeTrailer;
      PH_DONE:    code = CodeDone;
      PH_INVALID: code = CodeInvalid;
      default:    code = CodeInvalid;
    endcase
    return code;
  endfunction

endpackage

@@ design/ctd_front.sv @@
// ----------------------------------------------------------------------------
// ctd_front
// Accepts request words and classifies framing bytes ahead of the queue.
// ----------------------------------------------------------------------------
module ctd_front (
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [ctd_pkg::InDataW-1:0] s_axis_tdata_i,  // byte_in, consume_count
  input  logic [1:0]                 s_axis_tuser_i,  // req_type
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output ctd_pkg::cmd_t              q_cmd_o
);
  import ctd_pkg::*;

  localparam logic [7:0] ByteCr   = 8'h0D;
  localparam logic [7:0] ByteLf   = 8'h0A;
  localparam logic [7:0] ByteSp   = 8'h20;
  localparam logic [7:0] ByteTab  = 8'h09;
  localparam logic [7:0] ByteSemi = 8'h3B;

  logic [7:0] byte_in;
  logic       is_dec, is_lc, is_uc;

  assign byte_in = s_axis_tdata_i[7:0];
  assign is_dec  = (byte_in >= 8'h30) && (byte_in <= 8'h39);
  assign is_lc   = (byte_in >= 8'h61) && (byte_in <= 8'h66);
  assign is_uc   = (byte_in >= 8'h41) && (byte_in <= 8'h46);

  always_comb begin
    q_cmd_o.req   = req_e'(s_axis_tuser_i);
    q_cmd_o.count = s_axis_tdata_i[8 +: CountW];
    q_cmd_o.hex   = 4'd0;
    priority if (byte_in == ByteCr) begin
      q_cmd_o.cls = CLS_CR;
    end else if (byte_in == ByteLf) begin
      q_cmd_o.cls = CLS_LF;
    end else if ((byte_in == ByteSp) || (byte_in == ByteTab)) begin
      q_cmd_o.cls = CLS_WS;
    end else if (byte_in == ByteSemi) begin
      q_cmd_o.cls = CLS_SEMI;
    end else if (is_dec) begin
      q_cmd_o.cls = CLS_HEX;
      q_cmd_o.hex = byte_in[3:0];
    end else if (is_lc || is_uc) begin
      // 'a'..'f' and 'A'..'F' share the low nibble 1..6
      q_cmd_o.cls = CLS_HEX;
      q_cmd_o.hex = byte_in[3:0] + 4'd9;
    end else begin
      q_cmd_o.cls = CLS_OTHER;
    end
  end

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

endmodule

@@ design/ctd_fifo.sv @@
// ----------------------------------------------------------------------------
// ctd_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module ctd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ctd_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ctd_pkg::cmd_t pop_cmd_o
);
  import ctd_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o    = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  function automatic logic [FifoPtrW-1:0] ptr_inc(logic [FifoPtrW-1:0] p);
    return (p == FifoPtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + FifoCntW'(do_push) - FifoCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ design/ctd_back.sv @@
// ----------------------------------------------------------------------------
// ctd_back
// Framing state machine and output register for the chunked decoder.
// ----------------------------------------------------------------------------
module ctd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  ctd_pkg::cmd_t               q_cmd_i,
  output logic                        q_pop_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [ctd_pkg::OutDataW-1:0] m_axis_tdata_o  // phase_code, bytes_left
);
  import ctd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic                digit_q, digit_d;
  logic                tle_q, tle_d;
  logic                out_vld_q, out_vld_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                take;
  logic                finish_bad, finish_zero;

  // advance when the output slot is free or being drained
  assign take    = !q_empty_i && (!out_vld_q || m_axis_tready_i);
  assign q_pop_o = take;

  assign finish_bad  = !digit_q;
  assign finish_zero = (rem_q == '0);

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    digit_d = digit_q;
    tle_d   = tle_q;
    if (take) begin
      unique case (q_cmd_i.req)
        REQ_BYTE: begin
          unique case (phase_q)
            PH_SIZE: begin
              unique case (q_cmd_i.cls)
                CLS_CR, CLS_WS: ;
                CLS_LF: begin
                  priority if (finish_bad) begin
                    phase_d = PH_INVALID;
                  end else if (finish_zero) begin
                    phase_d = PH_TRAILER;
                    tle_d   = 1'b1;
                  end else begin
                    phase_d = PH_DATA;
                  end
                end
                CLS_SEMI: phase_d = digit_q ? PH_EXT : PH_INVALID;
                CLS_HEX: begin
                  if (rem_q > SizeLimit) begin
                    phase_d = PH_INVALID;
                  end else begin
                    rem_d   = {rem_q[CountW-5:0], q_cmd_i.hex};
                    digit_d = 1'b1;
                  end
                end
                default: phase_d = PH_INVALID;
              endcase
            end
            PH_EXT: begin
              if (q_cmd_i.cls == CLS_LF) begin
                priority if (finish_bad) begin
                  phase_d = PH_INVALID;
                end else if (finish_zero) begin
                  phase_d = PH_TRAILER;
                  tle_d   = 1'b1;
                end else begin
                  phase_d = PH_DATA;
                end
              end
            end
            PH_DEND: begin
              if (q_cmd_i.cls != CLS_CR) begin
                phase_d = (q_cmd_i.cls == CLS_LF) ? PH_SIZE : PH_INVALID;
                rem_d   = '0;
                digit_d = 1'b0;
              end
            end
            PH_TRAILER: begin
              if (q_cmd_i.cls == CLS_LF) begin
                if (tle_q) begin
                  phase_d = PH_DONE;
                end
                tle_d = 1'b1;
              end else if (q_cmd_i.cls != CLS_CR) begin
                tle_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
        REQ_CONSUME: begin
          if (phase_q == PH_DATA) begin
            // saturate at zero and close the chunk body
            if (q_cmd_i.count < rem_q) begin
              rem_d = rem_q - q_cmd_i.count;
            end else begin
              rem_d   = '0;
              phase_d = PH_DEND;
            end
          end
        end
        REQ_RESTART: begin
          phase_d = PH_SIZE;
          rem_d   = '0;
          digit_d = 1'b0;
          tle_d   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (take) begin
      out_vld_d  = 1'b1;
      out_data_d = {{(OutDataW - CountW - 3){1'b0}}, rem_d, phase_code(phase_d)};
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIZE;
      rem_q     <= '0;
      digit_q   <= 1'b0;
      tle_q     <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      rem_q     <= rem_d;
      digit_q   <= digit_d;
      tle_q     <= tle_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != '0))
    else $error("data phase with zero bytes left");

  a_zero_after_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_DEND) || (phase_q == PH_TRAILER) || (phase_q == PH_DONE))
      |-> (rem_q == '0))
    else $error("remaining size not cleared after chunk body");

  a_ext_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXT) |-> digit_q)
    else $error("extension entered without a size digit");

  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |-> !q_pop_o)
    else $error("queue popped while result is stalled");

endmodule

@@ design/chunked_transfer_decoder_core.sv @@
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_core
// Tracks chunked transfer framing: size lines, body consumption, chunk ends
// and the trailer, reporting phase and remaining size for every word.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                                | tuser
//  s_axis    | in  | [7:0] byte_in, [39:8] consume_count  | [1:0] req_type
//  m_axis    | out | [2:0] phase_code, [34:3] bytes_left  | -
//
//  One word per clock sustained while m_axis accepts; one result word per input word.
//  Each word passes through a queue write, then the state update into the
//  output register.
//  Input ready depends only on the two-entry queue being full, so a stall
//  on m_axis backs up through the queue before s_axis stalls.
//  Reset is asynchronous; the decoder comes up in the size phase.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [ctd_pkg::InDataW-1:0]  s_axis_tdata_i,  // byte_in, consume_count
  input  logic [1:0]                  s_axis_tuser_i,  // req_type
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [ctd_pkg::OutDataW-1:0] m_axis_tdata_o   // phase_code, bytes_left
);
  import ctd_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;

  ctd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (full),
    .q_push_o        (push),
    .q_cmd_o         (push_cmd)
  );

  ctd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (pop_cmd)
  );

  ctd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (empty),
    .q_cmd_i         (pop_cmd),
    .q_pop_o         (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

@@ tb/chunked_transfer_decoder_core_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_core_checker
// Watches both stream channels of the decoder, predicts the phase and the
// remaining size for every accepted word and compares each result word
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_core_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [ctd_pkg::InDataW-1:0]  s_axis_tdata_i,   // byte_in, consume_count
  input  logic [1:0]                   s_axis_tuser_i,   // req_type
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  input  logic [ctd_pkg::OutDataW-1:0] m_axis_tdata_i,   // phase_code, bytes_left
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_count_o
);
  import ctd_pkg::*;

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChSemi = 8'h3B;

  typedef struct packed {
    logic [2:0]        phase_code;
    logic [CountW-1:0] bytes_left;
  } framing_status_t;

  framing_status_t   framing_expected[$];

  // predicted decoder state
  logic [2:0]        dec_phase;
  logic [CountW-1:0] dec_left;
  logic              dec_digit_seen;
  logic              dec_line_empty;

  function automatic int hex_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  task automatic clear_decoder();
    dec_phase      = CodeSize;
    dec_left       = '0;
    dec_digit_seen = 1'b0;
    dec_line_empty = 1'b1;
  endtask

  task automatic close_size_line();
    if (!dec_digit_seen) begin
      dec_phase = CodeInvalid;
    end else if (dec_left == '0) begin
      dec_phase      = CodeTrailer;
      dec_line_empty = 1'b1;
    end else begin
      dec_phase = CodeData;
    end
  endtask

  task automatic advance_decoder(input req_e req, input logic [7:0] b,
                                 input logic [CountW-1:0] n);
    int digit;
    case (req)
      REQ_BYTE: begin
        case (dec_phase)
          CodeSize: begin
            if (b == ChCr || b == ChSp || b == ChTab) begin
              // skip blanks inside the size line
            end else if (b == ChLf) begin
              close_size_line();
            end else if (b == ChSemi) begin
              dec_phase = dec_digit_seen ? CodeExt : CodeInvalid;
            end else begin
              digit = hex_value(b);
              if (digit < 0 || dec_left > SizeLimit) begin
                dec_phase = CodeInvalid;
              end else begin
                dec_left       = {dec_left[CountW-5:0], digit[3:0]};
                dec_digit_seen = 1'b1;
              end
            end
          end
          CodeExt: begin
            if (b == ChLf) close_size_line();
          end
          CodeDend: begin
            if (b != ChCr) begin
              dec_phase      = (b == ChLf) ? CodeSize : CodeInvalid;
              dec_left       = '0;
              dec_digit_seen = 1'b0;
            end
          end
          CodeTrailer: begin
            if (b == ChLf) begin
              if (dec_line_empty) dec_phase = CodeDone;
              dec_line_empty = 1'b1;
            end else if (b != ChCr) begin
              dec_line_empty = 1'b0;
            end
          end
          default: ;
        endcase
      end
      REQ_CONSUME: begin
        if (dec_phase == CodeData) begin
          dec_left = (n < dec_left) ? dec_left - n : '0;
          if (dec_left == '0) dec_phase = CodeDend;
        end
      end
      REQ_RESTART: clear_decoder();
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [CountW-1:0] want,
                                 input logic [CountW-1:0] got);
    $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    framing_status_t got;
    framing_status_t want;
    if (!rst_ni) begin
      clear_decoder();
      framing_expected.delete();
      mismatch_count_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.phase_code = m_axis_tdata_i[2:0];
        got.bytes_left = m_axis_tdata_i[CountW+2:3];
        if (framing_expected.size() == 0) begin
          report_mismatch("result word with nothing expected", '0, got.bytes_left);
        end else begin
          want = framing_expected.pop_front();
          if (got.phase_code != want.phase_code)
            report_mismatch("phase_code", CountW'(want.phase_code),
                            CountW'(got.phase_code));
          if (got.bytes_left != want.bytes_left)
            report_mismatch("bytes_left", want.bytes_left, got.bytes_left);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        advance_decoder(req_e'(s_axis_tuser_i), s_axis_tdata_i[7:0],
                        s_axis_tdata_i[CountW+7:8]);
        framing_expected.push_back('{dec_phase, dec_left});
      end
    end
    pending_count_o = framing_expected.size();
  end

endmodule

@@ tb/chunked_transfer_decoder_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_core_test
// Drives framing bytes, body consumption and restarts into the decoder: a
// short directed run over the corner cases, then randomized chunked messages
// with noise, under changing stall patterns on both channels.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_core_test;
  import ctd_pkg::*;

  localparam int unsigned WordTarget    = 1200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldOffCycles = 64;

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChSemi = 8'h3B;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;   // byte_in, consume_count
  logic [1:0]          s_axis_tuser_i;   // req_type
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;   // phase_code, bytes_left

  int unsigned mismatches;
  int unsigned pending_results;
  int unsigned words_sent;
  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned quiet_cycles;
  logic        hold_off_req;

  chunked_transfer_decoder_core u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  chunked_transfer_decoder_core_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i   (m_axis_tdata_o),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // end the run if neither channel moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("chunked_transfer_decoder_core_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        // hold off long enough for the input side to back up
        m_axis_tready_i <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  task automatic send_word(input req_e req, input logic [7:0] byte_val,
                           input logic [CountW-1:0] count);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {count, byte_val};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_char(input logic [7:0] b);
    send_word(REQ_BYTE, b, $urandom);
  endtask

  task automatic send_consume(input logic [CountW-1:0] n);
    send_word(REQ_CONSUME, 8'($urandom), n);
  endtask

  task automatic send_restart();
    send_word(REQ_RESTART, 8'($urandom), $urandom);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return "0" + {4'd0, d};
    return ($urandom_range(1) ? "a" : "A") + {4'd0, d} - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(2))
      0:       return ChSp;
      1:       return ChTab;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [7:0] line_char();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == ChCr || b == ChLf) b = "x";
    return b;
  endfunction

  task automatic send_size_line(input logic [CountW-1:0] size);
    int digits;
    logic [7:0] b;
    digits = 1;
    while (digits < 8 && (size >> (4 * digits)) != 0) digits++;
    if ($urandom_range(3) == 0) send_char(blank_char());
    if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) send_char("0");
    for (int i = digits - 1; i >= 0; i--) send_char(hex_char(size[4*i +: 4]));
    if ($urandom_range(3) == 0) send_char(blank_char());
    if ($urandom_range(3) == 0) begin
      send_char(ChSemi);
      repeat ($urandom_range(4)) begin
        b = 8'($urandom);
        send_char((b == ChLf) ? 8'h3D : b);
      end
    end
    if ($urandom_range(7) != 0) send_char(ChCr);
    send_char(ChLf);
  endtask

  // one chunked message: data chunks, last chunk, trailer, with rare breakage
  task automatic send_message();
    int unsigned chunks;
    logic [CountW-1:0] size;
    logic [CountW-1:0] left;
    logic [CountW-1:0] n;
    send_restart();
    chunks = $urandom_range(3);
    for (int c = 0; c < chunks; c++) begin
      case ($urandom_range(7))
        0:       size = $urandom;
        1:       size = $urandom_range(4096, 65);
        default: size = $urandom_range(64, 1);
      endcase
      if (size == '0) size = 1;
      if ($urandom_range(19) == 0) send_char(8'($urandom));
      send_size_line(size);
      left = size;
      while (left != '0) begin
        if ($urandom_range(9) == 0) send_char(8'($urandom));
        case ($urandom_range(9))
          0:       n = '0;
          1:       n = $urandom;
          default: n = $urandom_range(left, 1);
        endcase
        send_consume(n);
        left = (n < left) ? left - n : '0;
      end
      case ($urandom_range(15))
        0: send_char(8'($urandom));
        1: send_char(ChLf);
        2: begin
          send_char(ChCr);
          send_char(ChCr);
          send_char(ChLf);
        end
        default: begin
          send_char(ChCr);
          send_char(ChLf);
        end
      endcase
    end
    send_size_line('0);
    repeat ($urandom_range(2)) begin
      repeat ($urandom_range(6, 1)) send_char(line_char());
      send_char(ChCr);
      send_char(ChLf);
    end
    send_char(ChCr);
    send_char(ChLf);
    // drop a few bytes after the end; done holds until restart
    if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) send_char(8'($urandom));
  endtask

  initial begin : stimulus
    logic hold_off_done;
    hold_off_done   = 1'b0;
    hold_off_req    = 1'b0;
    words_sent      = 0;
    src_idle_pct    = 6;
    dst_idle_pct    = 81;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_BYTE;
    rst_ni          = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corner cases
    send_word(REQ_NONE, 8'hFF, '1);
    send_consume('1);
    send_char(ChSemi);
    send_char(8'h00);
    send_restart();
    send_char(ChLf);
    send_restart();
    send_char(8'hFF);
    send_restart();
    repeat (8) send_char("F");
    send_char("a");
    send_restart();
    send_char("2");
    send_char(ChLf);
    send_consume('0);
    send_char("x");
    send_consume('1);
    send_char("Z");

    while (words_sent < WordTarget) begin
      if (words_sent < WordTarget / 3) begin
        src_idle_pct = 6;
        dst_idle_pct = 81;
      end else if (words_sent < 2 * WordTarget / 3) begin
        src_idle_pct = 81;
        dst_idle_pct = 6;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
        if (!hold_off_done) begin
          hold_off_req  = 1'b1;
          hold_off_done = 1'b1;
        end
      end
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(15, 5))
          send_word(req_e'($urandom_range(3)), 8'($urandom), $urandom);
      end else begin
        send_message();
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("chunked_transfer_decoder_core_test passed");
    end else begin
      $display("chunked_transfer_decoder_core_test failed");
    end
    $finish;
  end

endmodule

@@ chunked_transfer_decoder_core.f @@
design/ctd_pkg.sv
design/ctd_front.sv
design/ctd_fifo.sv
design/ctd_back.sv
design/chunked_transfer_decoder_core.sv
tb/chunked_transfer_decoder_core_checker.sv
tb/chunked_transfer_decoder_core_test.sv
